// ===== design/acsl_pkg.sv =====
package acsl_pkg;

    localparam int NUM_COEF_REGS = 5;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_CHAN0_COEFS = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIFF_TWOS   = 3'd5;

    localparam logic [2:0] SE_CHANNEL = 3'd2;

    localparam logic signed [23:0] ONE_Q12     = 24'sd4096;
    localparam logic signed [23:0] NEG_ONE_Q12 = -24'sd4096;
    localparam logic signed [23:0] Q24_MAX     = 24'sd8388607;
    localparam logic signed [23:0] Q24_MIN     = -24'sd8388608;
    localparam logic [11:0] CODE_SIGN          = 12'h800;
    localparam logic signed [12:0] CODE_BIAS   = 13'sd2048;

    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 17;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    typedef logic [CFG_DATA_W-1:0] coef_word_t;

    typedef struct packed {
        coef_word_t [NUM_COEF_REGS-1:0] coef;
        logic                           twos;
    } cfg_t;

    typedef struct packed {
        logic                       en;
        logic signed [MUL_A_W-1:0]  a;
        logic signed [MUL_B_W-1:0]  b;
    } mul_req_t;

endpackage

// ===== design/acsl_cfg_regs.sv =====
module acsl_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [acsl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [acsl_pkg::CFG_DATA_W-1:0]    cfg_data,
    output acsl_pkg::cfg_t                     cfg
);

    acsl_pkg::coef_word_t [acsl_pkg::NUM_COEF_REGS-1:0] coef_reg;
    logic                                               twos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg <= '0;
            twos_reg <= 1'b1;
        end else if (cfg_we) begin
            if (cfg_index < acsl_pkg::CFG_INDEX_W'(acsl_pkg::NUM_COEF_REGS)) begin
                coef_reg[cfg_index - acsl_pkg::REG_CHAN0_COEFS] <= cfg_data;
            end else if (cfg_index == acsl_pkg::REG_DIFF_TWOS) begin
                twos_reg <= cfg_data[0];
            end
        end
    end

    assign cfg.coef = coef_reg;
    assign cfg.twos = twos_reg;

endmodule

// ===== design/acsl_mul.sv =====
module acsl_mul (
    input  logic                                    aclk,
    input  acsl_pkg::mul_req_t                      req,
    output logic signed [acsl_pkg::PROD_W-1:0]      prod
);

    logic signed [acsl_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg <= acsl_pkg::PROD_W'(req.a) * acsl_pkg::PROD_W'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== design/acsl_seq.sv =====
module acsl_seq #(
    parameter int LIMIT = 5
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  acsl_pkg::cfg_t                      cfg,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [63:0]                         m_tdata,
    output logic                                m_tuser,
    output acsl_pkg::mul_req_t                  mul_req,
    input  logic signed [acsl_pkg::PROD_W-1:0]  prod
);

    localparam int IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ADD1 = 2'd1;
    localparam logic [1:0] ST_MUL2 = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [2:0]              ch_reg;
    logic signed [12:0]      dcode_reg;
    logic signed [23:0]      x_reg;
    logic [LIMIT-1:0]        seeded_reg;
    logic signed [23:0]      store_mem [LIMIT];
    logic                    m_tvalid_reg;
    logic [63:0]             m_tdata_reg;
    logic                    m_tuser_reg;

    logic                    accept, in_range, take_sample, out_free, finish;
    logic [2:0]              in_ch;
    logic [11:0]             in_code;
    logic signed [12:0]      in_dcode;
    acsl_pkg::coef_word_t    coef_in, coef_cur;
    logic [IDX_W-1:0]        idx;
    logic signed [23:0]      y_cur, offset, x_sat, x_clamp, f_sat, y_new;
    logic signed [43:0]      acc, fadd;
    logic signed [33:0]      acc_rnd, fsum;
    logic signed [27:0]      f_rnd;
    logic signed [24:0]      diff;

    function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
        logic signed [23:0] r;
        if (v > 34'(acsl_pkg::Q24_MAX)) begin
            r = acsl_pkg::Q24_MAX;
        end else if (v < 34'(acsl_pkg::Q24_MIN)) begin
            r = acsl_pkg::Q24_MIN;
        end else begin
            r = v[23:0];
        end
        return r;
    endfunction

    assign s_tready    = (state_reg == ST_IDLE);
    assign accept      = s_tvalid && s_tready;
    assign in_ch       = s_tdata[2:0];
    assign in_code     = s_tdata[14:3];
    assign in_range    = (in_ch < 3'(LIMIT));
    assign take_sample = accept && !s_tuser && in_range;

    always_comb begin
        if (in_ch == acsl_pkg::SE_CHANNEL) begin
            in_dcode = {1'b0, in_code};
        end else if (cfg.twos) begin
            in_dcode = {in_code[11], in_code};
        end else begin
            in_dcode = $signed({1'b0, in_code}) - acsl_pkg::CODE_BIAS;
        end
    end

    assign coef_in  = in_range ? cfg.coef[in_ch] : '0;
    assign coef_cur = cfg.coef[ch_reg];
    assign idx      = ch_reg[IDX_W-1:0];
    assign y_cur    = store_mem[idx];
    assign offset   = coef_cur[39:16];

    // scale and round: gain*code + offset*1024 at 22 fraction bits
    assign acc     = 44'(prod) + (44'(offset) <<< 10) + 44'sd512;
    assign acc_rnd = acc[43:10];
    assign x_sat   = sat24(acc_rnd);

    always_comb begin
        x_clamp = x_sat;
        if (ch_reg == acsl_pkg::SE_CHANNEL) begin
            if (x_sat > acsl_pkg::ONE_Q12) begin
                x_clamp = acsl_pkg::ONE_Q12;
            end else if (x_sat < acsl_pkg::NEG_ONE_Q12) begin
                x_clamp = acsl_pkg::NEG_ONE_Q12;
            end
        end
    end

    assign diff  = 25'(x_reg) - 25'(y_cur);
    assign fadd  = 44'(prod) + 44'sd32768;
    assign f_rnd = fadd[43:16];
    assign fsum  = 34'(y_cur) + 34'(f_rnd);
    assign f_sat = sat24(fsum);
    assign y_new = seeded_reg[idx] ? f_sat : x_reg;

    always_comb begin
        mul_req.en = take_sample || (state_reg == ST_MUL2);
        if (state_reg == ST_MUL2) begin
            mul_req.a = diff;
            mul_req.b = {1'b0, coef_cur[15:0]};
        end else begin
            mul_req.a = 25'(signed'(coef_in[63:40]));
            mul_req.b = 17'(in_dcode);
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign finish   = (state_reg == ST_DONE) && out_free;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (take_sample) state_next = ST_ADD1;
            ST_ADD1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            seeded_reg   <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept && s_tuser) begin
                seeded_reg <= '0;
            end else if (finish) begin
                seeded_reg[idx] <= 1'b1;
            end
            if (finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take_sample) begin
            ch_reg    <= in_ch;
            dcode_reg <= in_dcode;
        end
        if (state_reg == ST_ADD1) begin
            x_reg <= x_clamp;
        end
        if (finish) begin
            store_mem[idx] <= y_new;
            m_tdata_reg    <= {y_new, x_reg, dcode_reg, ch_reg};
            m_tuser_reg    <= !seeded_reg[idx];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_sample_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        take_sample |=> state_reg == ST_ADD1)
        else $error("accepted sample did not start the sequence");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside the final step");

    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser) |=> seeded_reg == '0)
        else $error("clear request left a filter seeded");

    a_busy_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !out_free) |=> state_reg == ST_DONE)
        else $error("sequence left write-back while output stalled");

endmodule

// ===== design/adc_channel_scale_lowpass_core.sv =====
// Channel   Direction  Ports                       Content
// s_        in         tvalid tready tdata tuser   sample or clear request
// m_        out        tvalid tready tdata tuser   scaled and filtered result
// cfg_      in         we index data               coefficient and format registers
//
// A sample request runs in order through accept with gain multiply, round and
// saturate, filter multiply and write-back, which share one multiplier.
// Clear and out-of-range requests give no result.
// Write-back waits while the output register holds an untaken result.
// Reset is synchronous, active low; filters start unseeded.
module adc_channel_scale_lowpass_core #(
    parameter int NUM_CHANNELS = 5
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [23:0]                        s_tdata,   // channel[2:0], raw_word[14:3]
    input  logic                               s_tuser,   // mode
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [63:0]                        m_tdata,   // chan_out, decoded_code,
                                                          // scaled_value, filtered_value
    output logic                               m_tuser,   // filter was unseeded
    input  logic                               cfg_we,
    input  logic [acsl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [acsl_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int LIMIT = (NUM_CHANNELS < acsl_pkg::NUM_COEF_REGS) ?
                           NUM_CHANNELS : acsl_pkg::NUM_COEF_REGS;

    acsl_pkg::cfg_t                      cfg;
    acsl_pkg::mul_req_t                  mul_req;
    logic signed [acsl_pkg::PROD_W-1:0]  prod;

    acsl_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    acsl_mul u_mul (
        .aclk (aclk),
        .req  (mul_req),
        .prod (prod)
    );

    acsl_seq #(
        .LIMIT (LIMIT)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .mul_req  (mul_req),
        .prod     (prod)
    );

endmodule
